// File: rtl/wve_pkg.sv
// Shared types, widths and constants of the weighted velocity estimator.
package wve_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;

	localparam int CMD_W     = 2;
	localparam int POS_W     = 24;
	localparam int STAMP_W   = 32;
	localparam int TU_W      = 16;
	localparam int VEL_W     = 32;
	localparam int PAIRS_W   = 3;
	localparam int PAIRS_MAX = 7;

	// Q4.12 weight, 10.0 at the start of a walk
	localparam int WEIGHT_W = 16;
	localparam logic [WEIGHT_W-1:0] WEIGHT_START = 16'd40960;
	// Geometric sum of the weights stays below 4 * 10.0
	localparam int TOTW_W = 18;

	localparam int DIFF_W  = POS_W + 1;
	localparam int PROD_W  = DIFF_W + TU_W + 1;
	localparam int WPROD_W = WEIGHT_W + 1 + VEL_W;
	localparam int SUM_W   = WPROD_W + 1;
	localparam int DEN_W   = STAMP_W;

	localparam logic [TU_W-1:0] TU_RESET = 16'd1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 2'd0,
		CMD_COMPUTE = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [STAMP_W-1:0] t;
	} sample_t;

endpackage

// File: rtl/weighted_velocity_estimator.sv
// Weighted velocity estimator: ring of position samples and a pair-walking sequencer.
// Add and clear words leave the sequencer idle; the next word is accepted in the following cycle.
// Compute walks pairs oldest to newest: a used pair is multiplied, divided in the serial dividers,
// weighted and accumulated; equal-stamp pairs are skipped; a final division gives the weighted
// mean unless no pair is used. One compute at a time; the result register lets the next word in.
// Reset clears the sequencer, ring pointers and time_units (1000); sample memory is not cleared.
module weighted_velocity_estimator #(
	parameter int HISTORY_DEPTH = wve_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [wve_pkg::CMD_W-1:0]           command,
	input  logic signed [wve_pkg::POS_W-1:0]    x_pos,
	input  logic signed [wve_pkg::POS_W-1:0]    y_pos,
	input  logic [wve_pkg::STAMP_W-1:0]         stamp,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wve_pkg::VEL_W-1:0]    vel_x,
	output logic signed [wve_pkg::VEL_W-1:0]    vel_y,
	output logic [wve_pkg::PAIRS_W-1:0]         pairs_used,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wve_pkg::TU_W-1:0]            cfg_data
);
	import wve_pkg::*;

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_REF    = 11'b000_0000_0010,
		S_CUR    = 11'b000_0000_0100,
		S_MUL    = 11'b000_0000_1000,
		S_DSTART = 11'b000_0001_0000,
		S_DWAIT  = 11'b000_0010_0000,
		S_WMUL   = 11'b000_0100_0000,
		S_ACC    = 11'b000_1000_0000,
		S_FIN    = 11'b001_0000_0000,
		S_FWAIT  = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [TU_W-1:0]  time_units_q;
	logic [IDX_W-1:0] oldest_q, ptr_q;
	logic [CNT_W-1:0] count_q, k_q, n_q, used_q;

	sample_t ref_q, cur;
	sample_t rd_data_w;
	logic signed [DIFF_W-1:0]  dx_q, dy_q;
	logic signed [DEN_W-1:0]   dt_q;
	logic signed [PROD_W-1:0]  prod_x_q, prod_y_q;
	logic signed [VEL_W-1:0]   px_q, py_q;
	logic signed [WPROD_W-1:0] wprod_x_q, wprod_y_q;
	logic signed [SUM_W-1:0]   sum_x_q, sum_y_q;
	logic [TOTW_W-1:0]         total_w_q;
	logic [WEIGHT_W-1:0]       w_q;
	logic [WEIGHT_W+1:0]       w3;
	logic signed [VEL_W-1:0]   res_x_q, res_y_q;

	logic                      accept, do_add, do_clear, do_compute;
	logic                      full, more, rd_en, rd_issue;
	logic [IDX_W-1:0]          rd_addr, wr_slot;
	logic [CNT_W:0]            slot_sum;
	logic [DEN_W-1:0]          dt_w;
	logic                      div_start, div_done_x, div_done_y, div_done;
	logic signed [SUM_W-1:0]   div_num_x, div_num_y;
	logic signed [DEN_W-1:0]   div_den;
	logic signed [VEL_W-1:0]   quo_x, quo_y;
	logic                      out_valid_q, out_load;
	logic signed [VEL_W-1:0]   vel_x_q, vel_y_q;
	logic [PAIRS_W-1:0]        pairs_q;
	logic [CNT_W+2:0]          used_ext;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_units_q <= TU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			time_units_q <= cfg_data;
		end
	end

	// input side
	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign do_add     = accept && (command == CMD_ADD);
	assign do_clear   = accept && (command == CMD_CLEAR);
	assign do_compute = accept && (command == CMD_COMPUTE);

	assign full     = (count_q == CNT_W'(HISTORY_DEPTH));
	assign slot_sum = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(count_q);

	always_comb begin
		if (full) begin
			wr_slot = oldest_q;
		end else if (slot_sum >= (CNT_W+1)'(HISTORY_DEPTH)) begin
			wr_slot = IDX_W'(slot_sum - (CNT_W+1)'(HISTORY_DEPTH));
		end else begin
			wr_slot = IDX_W'(slot_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else if (do_clear) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else if (do_add) begin
			if (full) begin
				oldest_q <= next_idx(oldest_q);
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// sample memory
	assign cur  = rd_data_w;

	wve_sample_mem #(
		.DEPTH (HISTORY_DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (do_add),
		.wr_addr (wr_slot),
		.wr_data ({x_pos, y_pos, stamp}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data_w)
	);

	assign more = (k_q < n_q);
	assign dt_w = cur.t - ref_q.t;

	// both dividers run in lockstep
	assign div_done = div_done_x && div_done_y;

	// sequencer
	always_comb begin
		state_d  = state_q;
		rd_issue = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (do_compute) state_d = S_REF;
			end
			S_REF: begin
				if (more) begin
					rd_issue = 1'b1;
					state_d  = S_CUR;
				end else begin
					state_d = S_FIN;
				end
			end
			S_CUR: begin
				if (dt_w != '0) begin
					state_d = S_MUL;
				end else if (more) begin
					// equal stamps: drop the pair, keep the reference
					rd_issue = 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MUL:    state_d = S_DSTART;
			S_DSTART: state_d = S_DWAIT;
			S_DWAIT: begin
				if (div_done) state_d = S_WMUL;
			end
			S_WMUL:   state_d = S_ACC;
			S_ACC: begin
				if (more) begin
					rd_issue = 1'b1;
					state_d  = S_CUR;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = (used_q != '0) ? S_FWAIT : S_OUT;
			end
			S_FWAIT: begin
				if (div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rd_en   = do_compute || rd_issue;
	assign rd_addr = (state_q == S_IDLE) ? oldest_q : ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign w3 = {2'b00, w_q} + {1'b0, w_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			n_q    <= '0;
			used_q <= '0;
			ptr_q  <= '0;
		end else begin
			if (do_compute) begin
				k_q    <= CNT_W'(1);
				n_q    <= count_q;
				used_q <= '0;
				ptr_q  <= next_idx(oldest_q);
			end else if (rd_issue) begin
				k_q   <= k_q + 1'b1;
				ptr_q <= next_idx(ptr_q);
			end
			if (state_q == S_ACC) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				sum_x_q   <= '0;
				sum_y_q   <= '0;
				total_w_q <= '0;
				w_q       <= WEIGHT_START;
			end
			S_REF: begin
				ref_q <= cur;
			end
			S_CUR: begin
				if (dt_w != '0) begin
					dx_q  <= DIFF_W'($signed(cur.x)) - DIFF_W'($signed(ref_q.x));
					dy_q  <= DIFF_W'($signed(cur.y)) - DIFF_W'($signed(ref_q.y));
					dt_q  <= $signed(dt_w);
					ref_q <= cur;
				end
			end
			S_MUL: begin
				prod_x_q <= dx_q * $signed({1'b0, time_units_q});
				prod_y_q <= dy_q * $signed({1'b0, time_units_q});
			end
			S_DWAIT: begin
				if (div_done) begin
					px_q <= quo_x;
					py_q <= quo_y;
				end
			end
			S_WMUL: begin
				wprod_x_q <= $signed({1'b0, w_q}) * px_q;
				wprod_y_q <= $signed({1'b0, w_q}) * py_q;
			end
			S_ACC: begin
				sum_x_q   <= sum_x_q + SUM_W'(wprod_x_q);
				sum_y_q   <= sum_y_q + SUM_W'(wprod_y_q);
				total_w_q <= total_w_q + TOTW_W'(w_q);
				w_q       <= w3[WEIGHT_W+1:2];
			end
			S_FIN: begin
				if (used_q == '0) begin
					res_x_q <= '0;
					res_y_q <= '0;
				end
			end
			S_FWAIT: begin
				if (div_done) begin
					res_x_q <= quo_x;
					res_y_q <= quo_y;
				end
			end
			default: begin
			end
		endcase
	end

	// shared dividers: per-pair velocity, then the weighted mean
	assign div_start = (state_q == S_DSTART) || ((state_q == S_FIN) && (used_q != '0));
	assign div_num_x = (state_q == S_FIN) ? sum_x_q : SUM_W'(prod_x_q);
	assign div_num_y = (state_q == S_FIN) ? sum_y_q : SUM_W'(prod_y_q);
	assign div_den   = (state_q == S_FIN) ? $signed(DEN_W'(total_w_q)) : dt_q;

	wve_divider #(
		.NUM_W (SUM_W),
		.DEN_W (DEN_W),
		.Q_W   (VEL_W)
	) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_x),
		.den    (div_den),
		.done   (div_done_x),
		.quo    (quo_x)
	);

	wve_divider #(
		.NUM_W (SUM_W),
		.DEN_W (DEN_W),
		.Q_W   (VEL_W)
	) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_y),
		.den    (div_den),
		.done   (div_done_y),
		.quo    (quo_y)
	);

	// result register
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign used_ext = (CNT_W+3)'(used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			vel_x_q <= res_x_q;
			vel_y_q <= res_y_q;
			// hold the count at its ceiling for deep histories
			pairs_q <= (used_ext > (CNT_W+3)'(PAIRS_MAX)) ? PAIRS_W'(PAIRS_MAX)
				: PAIRS_W'(used_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign vel_x      = vel_x_q;
	assign vel_y      = vel_y_q;
	assign pairs_used = pairs_q;

endmodule

// File: rtl/wve_sample_mem.sv
// Sample history memory: one write port, one read port, registered read data.
module wve_sample_mem #(
	parameter int DEPTH = wve_pkg::HISTORY_DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  wve_pkg::sample_t     wr_data,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output wve_pkg::sample_t     rd_data
);
	import wve_pkg::*;

	sample_t mem [DEPTH];
	sample_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/wve_divider.sv
// Serial signed divider, one quotient bit per cycle, truncating and saturating.
module wve_divider #(
	parameter int NUM_W = wve_pkg::SUM_W,
	parameter int DEN_W = wve_pkg::DEN_W,
	parameter int Q_W   = wve_pkg::VEL_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic                    done,
	output logic signed [Q_W-1:0]   quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [NUM_W-1:0] POS_LIM = {{(NUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
	localparam logic [NUM_W-1:0] NEG_LIM = POS_LIM + 1'b1;

	logic [NUM_W-1:0] num_u, num_mag;
	logic [DEN_W-1:0] den_u, den_mag;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic             neg_q, busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial, diff;
	logic             ge;
	logic [NUM_W-1:0] neg_mag;

	assign num_u   = num;
	assign den_u   = den;
	assign num_mag = num[NUM_W-1] ? (~num_u + 1'b1) : num_u;
	assign den_mag = den[DEN_W-1] ? (~den_u + 1'b1) : den_u;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num_mag;
			den_q <= den_mag;
			rem_q <= '0;
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
		end else if (busy_q) begin
			// shift the dividend out as quotient bits shift in
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign neg_mag = ~quo_q + 1'b1;

	always_comb begin
		if (neg_q) begin
			quo = (quo_q > NEG_LIM) ? {1'b1, {(Q_W-1){1'b0}}} : neg_mag[Q_W-1:0];
		end else begin
			quo = (quo_q > POS_LIM) ? {1'b0, {(Q_W-1){1'b1}}} : quo_q[Q_W-1:0];
		end
	end

	assign done = done_q;

endmodule

// File: tb/wve_checker.sv
// Checker for the weighted velocity estimator: watches all channels, predicts and compares.
module wve_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [wve_pkg::CMD_W-1:0]          command,
	input  logic signed [wve_pkg::POS_W-1:0]   x_pos,
	input  logic signed [wve_pkg::POS_W-1:0]   y_pos,
	input  logic [wve_pkg::STAMP_W-1:0]        stamp,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [wve_pkg::VEL_W-1:0]   vel_x,
	input  logic signed [wve_pkg::VEL_W-1:0]   vel_y,
	input  logic [wve_pkg::PAIRS_W-1:0]        pairs_used,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [wve_pkg::TU_W-1:0]           cfg_data,
	input  logic                               end_run,
	output int                                 errors,
	output int                                 pending
);
	import wve_pkg::*;

	localparam int DEPTH = HISTORY_DEPTH_DEF;

	typedef struct {
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic [PAIRS_W-1:0]      pairs;
	} motion_t;

	motion_t motion_q[$];

	logic [POS_W-1:0]   ring_x[DEPTH];
	logic [POS_W-1:0]   ring_y[DEPTH];
	logic [STAMP_W-1:0] ring_t[DEPTH];
	int unsigned        head;
	int unsigned        fill;
	logic [TU_W-1:0]    units;

	bit closed;
	int n_add, n_compute, n_clear, n_ignored, n_cfg, n_sat;
	logic [7:0] pairs_seen;

	initial begin
		errors = 0;
		pending = 0;
		closed = 0;
		n_add = 0;
		n_compute = 0;
		n_clear = 0;
		n_ignored = 0;
		n_cfg = 0;
		n_sat = 0;
		pairs_seen = '0;
		foreach (ring_x[i]) begin
			ring_x[i] = '0;
			ring_y[i] = '0;
			ring_t[i] = '0;
		end
	end

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		errors++;
	endtask

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Weighted finite-difference walk over the history, oldest to newest
	function automatic motion_t estimate();
		motion_t m;
		longint acc_x, acc_y, acc_w, dt, dx, dy;
		logic [STAMP_W-1:0] span;
		int unsigned wt, used, base, cur, k;
		acc_x = 0;
		acc_y = 0;
		acc_w = 0;
		wt = 32'(WEIGHT_START);
		used = 0;
		base = head;
		m.vx = '0;
		m.vy = '0;
		for (k = 1; k < fill; k++) begin
			cur = (head + k) % DEPTH;
			span = ring_t[cur] - ring_t[base];
			dt = longint'($signed(span));
			// equal stamps: keep the earlier sample as reference
			if (dt == 0)
				continue;
			dx = longint'($signed(ring_x[cur])) - longint'($signed(ring_x[base]));
			dy = longint'($signed(ring_y[cur])) - longint'($signed(ring_y[base]));
			acc_x += longint'(wt) * clamp32(dx * longint'(units) / dt);
			acc_y += longint'(wt) * clamp32(dy * longint'(units) / dt);
			acc_w += longint'(wt);
			wt = (wt * 3) >> 2;
			used++;
			base = cur;
		end
		if (used > 0) begin
			m.vx = VEL_W'(clamp32(acc_x / acc_w));
			m.vy = VEL_W'(clamp32(acc_y / acc_w));
		end
		m.pairs = PAIRS_W'((used > PAIRS_MAX) ? PAIRS_MAX : used);
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		motion_t want;
		int unsigned slot;
		if (!arst_n) begin
			head = 0;
			fill = 0;
			units = TU_RESET;
			motion_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (motion_q.size() == 0) begin
					report($sformatf("result word (%0d, %0d, %0d) with nothing expected",
						vel_x, vel_y, pairs_used));
				end else begin
					want = motion_q.pop_front();
					if (vel_x !== want.vx)
						report($sformatf("vel_x %0d, expected %0d", vel_x, want.vx));
					if (vel_y !== want.vy)
						report($sformatf("vel_y %0d, expected %0d", vel_y, want.vy));
					if (pairs_used !== want.pairs)
						report($sformatf("pairs_used %0d, expected %0d", pairs_used, want.pairs));
				end
			end
			if (cfg_valid && cfg_ready) begin
				units = cfg_data;
				n_cfg++;
			end
			if (in_valid && !in_stall) begin
				case (command)
					CMD_ADD: begin
						if (fill >= DEPTH) begin
							// drop the oldest sample
							slot = head;
							head = (head + 1) % DEPTH;
						end else begin
							slot = (head + fill) % DEPTH;
							fill++;
						end
						ring_x[slot] = x_pos;
						ring_y[slot] = y_pos;
						ring_t[slot] = stamp;
						n_add++;
					end
					CMD_COMPUTE: begin
						want = estimate();
						motion_q.push_back(want);
						pairs_seen[want.pairs] = 1'b1;
						if (want.vx == 32'sh7FFFFFFF || want.vx == 32'sh80000000 ||
								want.vy == 32'sh7FFFFFFF || want.vy == 32'sh80000000)
							n_sat++;
						n_compute++;
					end
					CMD_CLEAR: begin
						head = 0;
						fill = 0;
						n_clear++;
					end
					default: n_ignored++;
				endcase
			end
			if (end_run && !closed) begin
				closed = 1;
				while (motion_q.size() != 0) begin
					want = motion_q.pop_front();
					report($sformatf("expected result (%0d, %0d, %0d) never arrived",
						want.vx, want.vy, want.pairs));
				end
				$display("covered %0d adds, %0d computes, %0d clears, %0d ignored words, %0d writes",
					n_add, n_compute, n_clear, n_ignored, n_cfg);
				$display("pair counts seen (one bit per count) %08b, %0d results at a limit",
					pairs_seen, n_sat);
			end
		end
		pending = motion_q.size();
	end

endmodule

// File: tb/tb_weighted_velocity_estimator.sv
// Testbench top for the weighted velocity estimator: stimulus, idling and verdict.
module tb_weighted_velocity_estimator;
	import wve_pkg::*;

	localparam int WATCH_LIMIT = 6000;
	localparam int HOLD_OFF    = 1200;
	localparam int SETTLE      = 12;
	localparam int PHASE_ITEMS = 155;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [CMD_W-1:0]        command = '0;
	logic signed [POS_W-1:0] x_pos = '0;
	logic signed [POS_W-1:0] y_pos = '0;
	logic [STAMP_W-1:0]      stamp = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b1;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic [PAIRS_W-1:0]      pairs_used;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [TU_W-1:0]         cfg_data = '0;
	logic                    end_run = 1'b0;
	int                      errors;
	int                      pending;

	bit tx_calm = 0;
	bit rx_calm = 0;
	bit squeeze_go = 0;
	bit squeeze_done = 0;
	int n_items = 0;
	int quiet = 0;

	always #10 clk = ~clk;

	weighted_velocity_estimator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.stamp      (stamp),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.pairs_used (pairs_used),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	wve_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.stamp      (stamp),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.pairs_used (pairs_used),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.end_run    (end_run),
		.errors     (errors),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCH_LIMIT) begin
			$display("no word moved for %0d cycles", WATCH_LIMIT);
			$display("tb_weighted_velocity_estimator failed");
			$finish;
		end
	end

	function automatic int pause(input bit calm);
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	// Receiver: random hold-offs per result, one long hold-off on request
	initial begin
		int n;
		@(negedge clk);
		forever begin
			n = pause(rx_calm);
			if (squeeze_go && !squeeze_done) begin
				n = HOLD_OFF;
				squeeze_done = 1;
			end
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Call at a falling edge; returns at the falling edge after acceptance, valid still high
	task automatic push_word(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [STAMP_W-1:0] t);
		int gap;
		gap = pause(tx_calm);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		command = c;
		x_pos = x;
		y_pos = y;
		stamp = t;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (c != CMD_UNUSED)
			n_items++;
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		// add and clear words may still be in flight
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_units(input logic [TU_W-1:0] v);
		settle();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = TU_W'($urandom());
	endtask

	// One touch track: optional clear, a run of samples, then one or two computes
	task automatic track();
		int n, i, step;
		logic [STAMP_W-1:0] t;
		logic signed [POS_W-1:0] x, y;
		if ($urandom_range(0, 9) < 3)
			push_word(CMD_CLEAR, POS_W'($urandom()), POS_W'($urandom()), $urandom());
		n = $urandom_range(1, 10);
		t = $urandom();
		x = POS_W'($urandom());
		y = POS_W'($urandom());
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: t = t;
				1: t = $urandom();
				2: t = t - $urandom_range(1, 5000);
				default: t = t + $urandom_range(1, 5000);
			endcase
			if ($urandom_range(0, 4) == 0) begin
				x = POS_W'($urandom());
				y = POS_W'($urandom());
			end else begin
				step = $urandom_range(0, 8191);
				x = x + POS_W'(step - 4096);
				step = $urandom_range(0, 8191);
				y = y + POS_W'(step - 4096);
			end
			push_word(CMD_ADD, x, y, t);
		end
		push_word(CMD_COMPUTE, POS_W'($urandom()), POS_W'($urandom()), $urandom());
		if ($urandom_range(0, 3) == 0)
			push_word(CMD_COMPUTE, POS_W'($urandom()), POS_W'($urandom()), $urandom());
	endtask

	task automatic random_phase(input int target);
		while (n_items < target) begin
			if ($urandom_range(0, 9) < 7)
				track();
			else
				push_word(CMD_W'($urandom_range(0, 3)), POS_W'($urandom()),
					POS_W'($urandom()), $urandom());
		end
	endtask

	initial begin
		int phase, i;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at the reset value of time_units
		push_word(CMD_COMPUTE, '0, '0, '0);
		push_word(CMD_ADD, 24'h000000, 24'h000000, 32'd100);
		push_word(CMD_COMPUTE, '1, '1, '1);
		push_word(CMD_ADD, 24'h7FFFFF, 24'h800000, 32'd101);
		push_word(CMD_COMPUTE, '0, '0, '0);
		// equal stamp: skipped pair
		push_word(CMD_ADD, 24'h800000, 24'h7FFFFF, 32'd101);
		push_word(CMD_COMPUTE, '0, '0, '0);
		// most negative time difference
		push_word(CMD_ADD, 24'h000100, 24'hFFFF00, 32'h80000065);
		push_word(CMD_COMPUTE, '0, '0, '0);
		// stamp wraps past zero
		push_word(CMD_ADD, 24'h123456, 24'hABCDEF, 32'h00000010);
		push_word(CMD_UNUSED, POS_W'($urandom()), POS_W'($urandom()), $urandom());
		push_word(CMD_COMPUTE, '0, '0, '0);
		push_word(CMD_CLEAR, '0, '0, '0);
		push_word(CMD_COMPUTE, '0, '0, '0);
		// all stamps equal: no usable pair
		push_word(CMD_ADD, 24'd1, 24'd2, 32'd7);
		push_word(CMD_ADD, 24'd3, 24'd4, 32'd7);
		push_word(CMD_ADD, 24'd5, 24'd6, 32'd7);
		push_word(CMD_COMPUTE, '0, '0, '0);
		push_word(CMD_ADD, 24'hFFFFFF, 24'h000000, 32'hFFFFFFFF);
		push_word(CMD_COMPUTE, '0, '0, '0);
		settle();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				1: write_units(16'hFFFF);
				2: write_units(16'd1);
				3: write_units(16'd0);
				4: write_units(TU_W'($urandom()));
				5: write_units(TU_W'($urandom()));
				default: ;
			endcase
			tx_calm = (phase == 1);
			rx_calm = (phase == 1) || (phase == 3);
			random_phase(n_items + PHASE_ITEMS);
			if (phase == 2) begin
				// hold the receiver off while full histories keep coming
				squeeze_go = 1;
				tx_calm = 1;
				push_word(CMD_CLEAR, '0, '0, '0);
				for (i = 0; i < 8; i++)
					push_word(CMD_ADD, POS_W'($urandom()), POS_W'($urandom()),
						32'd1000 + 32'(i * 37));
				for (i = 0; i < 5; i++)
					push_word(CMD_COMPUTE, POS_W'($urandom()), POS_W'($urandom()),
						$urandom());
				tx_calm = 0;
			end
			settle();
		end

		settle();
		repeat (20) @(negedge clk);
		end_run = 1'b1;
		@(negedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("tb_weighted_velocity_estimator passed");
		else
			$display("tb_weighted_velocity_estimator failed");
		$finish;
	end

endmodule
